@@ rtl/core/cbts_pkg.sv @@
// Shared types and constants of the CAN bit timing search.
`timescale 1ns / 1ps

package cbts_pkg;

  localparam int unsigned CLK_W = 32;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned STEP_W = 5;

  localparam logic [9:0] QUANTA_MIN = 10'd8;
  localparam logic [9:0] QUANTA_MAX = 10'd256;
  localparam logic [9:0] SEG1_MIN = 10'd2;
  localparam logic [9:0] SEG1_MAX = 10'd255;
  localparam logic [9:0] SEG2_MIN = 10'd1;
  localparam logic [9:0] SEG2_MAX = 10'd127;
  localparam logic [2:0] SJW_MAX = 3'd4;

  // floor(x / 100) equals (x * 5243) >> 19 for every x below 43690.
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/core/can_bit_timing_search.sv @@
// Top level of the CAN bit timing search: sequencer, trial checks and stream ports.
`timescale 1ns / 1ps

// Channel   Direction  Width  Contents (lowest bit first)
// s_*       in         72     clock_hz[31:0], bit_rate[63:32], sample_percent[70:64]
// m_*       out        32     found, prescaler, segment_one, segment_two, jump_width
//
// One request is taken at a time; s_tready is high only while the sequencer is idle.
// Each prescaler trial runs a start step, the serial divider that forms quanta (32
// quotient bits and the capture), and then the sample-point product, the divide by 100
// and the checks.
// A request that finds nothing tries every prescaler up to MAX_PRESCALER; a zero bit rate
// skips the trials and answers not found. Reset is synchronous and needs no clearing pass.
// A finished result waits in the output register while the next search runs; the
// sequencer holds in its output step only if that register is still full.

module can_bit_timing_search
  import cbts_pkg::*;
#(
  parameter int unsigned MAX_PRESCALER = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // clock_hz[31:0], bit_rate[63:32], sample_percent[70:64], zero fill [71]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found[0], prescaler[11:1], segment_one[19:12], segment_two[26:20],
  // jump_width[29:27], zero fill [31:30]
  output logic [31:0] m_tdata
);

  localparam int unsigned PW = $clog2(MAX_PRESCALER + 1);
  localparam int unsigned DW = CLK_W + PW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_PROD  = 3'd3;
  localparam logic [2:0] ST_RECIP = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]       state;
  logic [CLK_W-1:0] clock_hz;
  logic [CLK_W-1:0] bit_rate;
  logic [PCT_W-1:0] pct;
  logic [PW-1:0]    presc;
  logic [DW-1:0]    divisor;

  logic             quanta_ok;
  logic [8:0]       quanta;
  logic [15:0]      prod;
  logic [9:0]       seg1;

  logic             res_found;
  logic [10:0]      res_presc;
  logic [7:0]       res_seg1;
  logic [6:0]       res_seg2;
  logic [2:0]       res_sjw;

  logic             div_start;
  logic [CLK_W-1:0] div_quot;
  div_status_t      div_stat;

  logic [28:0]      recip_full;
  logic [9:0]       q10;
  logic [9:0]       s2;
  logic             seg1_ok;
  logic             fits;
  logic             seg2_ok;
  logic             accept;

  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign div_start = (state == ST_START);

  cbts_divider #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clock_hz),
    .divisor  (divisor),
    .quotient (div_quot),
    .status   (div_stat)
  );

  // Trial checks on the registered quanta and segment one.
  assign recip_full = 29'(prod) * 29'(DIV100_RECIP);
  assign q10 = {1'b0, quanta};
  assign s2 = q10 - seg1 - 10'd1;
  assign seg1_ok = (seg1 >= SEG1_MIN) && (seg1 <= SEG1_MAX);
  assign fits = ((seg1 + 10'd1) <= q10);
  assign seg2_ok = (s2 >= SEG2_MIN) && (s2 <= SEG2_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // A new result enters the output register when it is empty or being drained.
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (s_tdata[63:32] == '0) ? ST_OUT : ST_START;
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          state <= ST_RECIP;
        end
        ST_RECIP: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if ((quanta_ok && seg1_ok && fits && seg2_ok) ||
              (presc == PW'(MAX_PRESCALER))) begin
            state <= ST_OUT;
          end else begin
            state <= ST_START;
          end
        end
        ST_OUT: begin
          // Hold the result here until the output register is free.
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          clock_hz  <= s_tdata[31:0];
          bit_rate  <= s_tdata[63:32];
          pct       <= s_tdata[70:64];
          presc     <= PW'(1);
          divisor   <= DW'(s_tdata[63:32]);
          res_found <= 1'b0;
          res_presc <= '0;
          res_seg1  <= '0;
          res_seg2  <= '0;
          res_sjw   <= '0;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          quanta_ok <= (div_quot >= CLK_W'(QUANTA_MIN)) && (div_quot <= CLK_W'(QUANTA_MAX));
          quanta    <= div_quot[8:0];
        end
      end
      ST_PROD: begin
        prod <= 16'(quanta) * 16'(pct);
      end
      ST_RECIP: begin
        seg1 <= recip_full[DIV100_SHIFT +: 10];
      end
      ST_CHECK: begin
        if (quanta_ok && seg1_ok && fits && seg2_ok) begin
          res_found <= 1'b1;
          res_presc <= 11'(presc);
          res_seg1  <= seg1[7:0];
          res_seg2  <= s2[6:0];
          res_sjw   <= (s2 > 10'(SJW_MAX)) ? SJW_MAX : s2[2:0];
        end else begin
          // Next prescaler: the divisor steps up by one bit rate.
          presc   <= presc + 1'b1;
          divisor <= divisor + DW'(bit_rate);
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {2'b00, res_sjw, res_seg2, res_seg1, res_presc, res_found};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/cbts_divider.sv @@
// Restoring serial divider, one quotient bit per cycle, shared by all trials.
`timescale 1ns / 1ps

module cbts_divider
  import cbts_pkg::*;
#(
  parameter int unsigned DW = 43
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CLK_W-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic [CLK_W-1:0] quotient,
  output div_status_t      status
);

  logic [DW-1:0]     rem;
  logic [CLK_W-1:0]  q;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              take;

  // The dividend shifts out of the top of q while quotient bits enter below.
  assign trial = {rem, q[CLK_W-1]};
  assign diff = trial - {1'b0, divisor};
  assign take = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
    end else if (busy) begin
      rem <= take ? diff[DW-1:0] : trial[DW-1:0];
      q   <= {q[CLK_W-2:0], take};
    end
  end

  assign quotient = q;
  assign status = '{busy: busy, done: done};

endmodule

@@ rtl/core/cbts_checker.sv @@
// Port-level assertions of the CAN bit timing search, bound to the top level.
`timescale 1ns / 1ps

module cbts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while a search is running");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[31:1] == 31'd0)
    else $error("not found result carries nonzero fields");

  a_found_sane: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[29:27] <= 3'd4) && (m_tdata[26:20] != 7'd0) &&
      (m_tdata[19:12] >= 8'd2) && ({4'd0, m_tdata[29:27]} <= m_tdata[26:20]))
    else $error("found result breaks the segment limits");

endmodule

bind can_bit_timing_search cbts_checker u_cbts_checker (.*);
